// ===== hdl/rlcf_pkg.sv =====
// ----------------------------------------------------------------------------
// rlcf_pkg
// Shared types and constants for the linear RGB colour fade core.
// ----------------------------------------------------------------------------
package rlcf_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned StepW    = 8;
  localparam int unsigned SkipW    = 15;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned ChanIdxW = 2;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 32;

  // The divider retires two quotient bits per cycle.
  localparam int unsigned DivCycles = ChanW / 2;
  localparam int unsigned DivCntW   = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_START_KEEP = 3'd0,
    CMD_START_SKIP = 3'd1,
    CMD_TICK       = 3'd2,
    CMD_LOCK       = 3'd3,
    CMD_UNLOCK     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/rlcf_div.sv =====
// ----------------------------------------------------------------------------
// rlcf_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rlcf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rlcf_pkg::ChanW-1:0]   dividend,
  input  logic [rlcf_pkg::StepW-1:0]   divisor,
  output logic [rlcf_pkg::ChanW-1:0]   quotient,
  output logic                         done
);

  logic [rlcf_pkg::StepW-1:0]   rem;
  logic [rlcf_pkg::ChanW-1:0]   dq;
  logic [rlcf_pkg::DivCntW-1:0] cnt;
  logic                         busy;

  logic [rlcf_pkg::StepW-1:0]   rem_next;
  logic [rlcf_pkg::ChanW-1:0]   dq_next;

  // Two restoring steps: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    logic [rlcf_pkg::StepW:0] trial;
    rem_next = rem;
    dq_next  = dq;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_next, dq_next[rlcf_pkg::ChanW-1]};
      if (trial >= {1'b0, divisor}) begin
        rem_next = rlcf_pkg::StepW'(trial - {1'b0, divisor});
        dq_next  = {dq_next[rlcf_pkg::ChanW-2:0], 1'b1};
      end else begin
        rem_next = trial[rlcf_pkg::StepW-1:0];
        dq_next  = {dq_next[rlcf_pkg::ChanW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == rlcf_pkg::DivCntW'(rlcf_pkg::DivCycles - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rlcf_pkg::DivCntW'(rlcf_pkg::DivCycles - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= dq_next;
    end
  end

  assign quotient = dq;

endmodule

// ===== hdl/rgb_linear_color_fade_core.sv =====
// ----------------------------------------------------------------------------
// rgb_linear_color_fade_core
// Fades an RGB colour linearly toward a target colour, one step per frame tick.
// ----------------------------------------------------------------------------
// Usage: each request on the slave channel carries a command in s_tuser and
// the colour, step and delay fields in s_tdata. Every request produces exactly
// one result on the master channel reporting the colour after the request,
// whether a fade is still running and whether start commands are locked out.
// Start commands load the start colour, goal colour and step count unless the
// block is locked; a start with skip also loads the delay count. A frame tick
// first consumes pending delay frames, then moves each channel by the
// remaining difference divided by the steps left, truncated toward zero.
// Timing: a fading tick runs the three channels one after another through a
// single shared divider, through DIV_START and DIV_WAIT for each channel,
// while other requests go straight to EMIT. The result register frees the
// input side, so a new request is taken while the previous result is still
// waiting. If the receiver stalls, a finished result waits in the sequencer
// until the result register is free; m_tdata holds steady while m_tvalid is
// high and m_tready is low.
// Reset (synchronous, rst high) clears the colours, counts and lock flag and
// drops any pending result.
// ----------------------------------------------------------------------------
module rgb_linear_color_fade_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: start_red, start_green, start_blue, goal_red,
  // goal_green, goal_blue, fade_steps, delay_frames (15 bits), one pad bit.
  input  logic [rlcf_pkg::InDataW-1:0]    s_tdata,
  // Fields from bit 0: command.
  input  logic [rlcf_pkg::CmdW-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: now_red, now_green, now_blue, fading, held, six pad bits.
  output logic [rlcf_pkg::OutDataW-1:0]   m_tdata
);

  rlcf_pkg::state_t state, state_next;

  logic [rlcf_pkg::ChanW-1:0]    color_now  [rlcf_pkg::NumChan];
  logic [rlcf_pkg::ChanW-1:0]    color_goal [rlcf_pkg::NumChan];
  logic [rlcf_pkg::StepW-1:0]    steps_rem;
  logic [rlcf_pkg::SkipW-1:0]    skip_rem;
  logic                          lock_flag;
  logic [rlcf_pkg::ChanIdxW-1:0] ch;
  logic                          neg;

  logic                          accept;
  logic                          div_start;
  logic                          div_done;
  logic                          out_load;
  logic                          cmd_fades;
  logic                          neg_c;
  logic [rlcf_pkg::ChanW-1:0]    mag;
  logic [rlcf_pkg::ChanW-1:0]    quot;
  logic [rlcf_pkg::ChanW:0]      sum;
  logic [rlcf_pkg::ChanW-1:0]    chan_new;
  rlcf_pkg::cmd_t                cmd;

  assign cmd    = rlcf_pkg::cmd_t'(s_tuser);
  assign accept = s_tvalid && s_tready;

  // A tick only needs the divider once the delay is spent and steps remain.
  assign cmd_fades = (cmd == rlcf_pkg::CMD_TICK) && (skip_rem == '0) && (steps_rem != '0);

  // Magnitude of the difference for the channel now being worked on.
  assign neg_c = color_goal[ch] < color_now[ch];
  assign mag   = neg_c ? (color_now[ch] - color_goal[ch]) : (color_goal[ch] - color_now[ch]);

  // Apply the truncated step; the clamps never fire for an in-range goal but
  // keep the channel within eight bits regardless.
  always_comb begin
    if (neg) begin
      sum      = {1'b0, color_now[ch]} - {1'b0, quot};
      chan_new = sum[rlcf_pkg::ChanW] ? '0 : sum[rlcf_pkg::ChanW-1:0];
    end else begin
      sum      = {1'b0, color_now[ch]} + {1'b0, quot};
      chan_new = sum[rlcf_pkg::ChanW] ? '1 : sum[rlcf_pkg::ChanW-1:0];
    end
  end

  rlcf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (steps_rem),
    .quotient (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      rlcf_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          state_next = cmd_fades ? rlcf_pkg::ST_DIV_START : rlcf_pkg::ST_EMIT;
        end
      end
      rlcf_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = rlcf_pkg::ST_DIV_WAIT;
      end
      rlcf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (ch == rlcf_pkg::ChanIdxW'(rlcf_pkg::NumChan - 1)) begin
            state_next = rlcf_pkg::ST_EMIT;
          end else begin
            state_next = rlcf_pkg::ST_DIV_START;
          end
        end
      end
      rlcf_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = rlcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rlcf_pkg::ST_IDLE;
      end
    endcase
  end

  // Fade state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rlcf_pkg::NumChan; i++) begin
        color_now[i]  <= '0;
        color_goal[i] <= '0;
      end
      steps_rem <= '0;
      skip_rem  <= '0;
      lock_flag <= 1'b0;
      ch        <= '0;
      neg       <= 1'b0;
    end else begin
      if (accept) begin
        ch <= '0;
        case (cmd)
          rlcf_pkg::CMD_START_KEEP, rlcf_pkg::CMD_START_SKIP: begin
            if (!lock_flag) begin
              for (int i = 0; i < rlcf_pkg::NumChan; i++) begin
                color_now[i]  <= s_tdata[i*rlcf_pkg::ChanW +: rlcf_pkg::ChanW];
                color_goal[i] <= s_tdata[(i+rlcf_pkg::NumChan)*rlcf_pkg::ChanW +:
                                         rlcf_pkg::ChanW];
              end
              steps_rem <= s_tdata[2*rlcf_pkg::NumChan*rlcf_pkg::ChanW +: rlcf_pkg::StepW];
              if (cmd == rlcf_pkg::CMD_START_SKIP) begin
                skip_rem <= s_tdata[2*rlcf_pkg::NumChan*rlcf_pkg::ChanW + rlcf_pkg::StepW +:
                                    rlcf_pkg::SkipW];
              end
            end
          end
          rlcf_pkg::CMD_TICK: begin
            if (skip_rem != '0) begin
              skip_rem <= skip_rem - 1'b1;
            end
          end
          rlcf_pkg::CMD_LOCK: begin
            lock_flag <= 1'b1;
          end
          rlcf_pkg::CMD_UNLOCK: begin
            lock_flag <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state == rlcf_pkg::ST_DIV_START) begin
        neg <= neg_c;
      end
      if ((state == rlcf_pkg::ST_DIV_WAIT) && div_done) begin
        color_now[ch] <= chan_new;
        if (ch == rlcf_pkg::ChanIdxW'(rlcf_pkg::NumChan - 1)) begin
          ch        <= '0;
          steps_rem <= steps_rem - 1'b1;
        end else begin
          ch <= ch + 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b0, lock_flag, (steps_rem != '0), color_now[2], color_now[1], color_now[0]};
    end
  end

endmodule

// ===== hdl/rlcf_checker.sv =====
// ----------------------------------------------------------------------------
// rlcf_checker
// Port-level checks for the linear RGB colour fade core.
// ----------------------------------------------------------------------------
module rlcf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rlcf_pkg::OutDataW-1:0] m_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The block is not ready in the cycle after it takes a request.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("block ready straight after a request");

  // The block only goes busy because a request was taken.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid))
    else $error("block went busy without a request");

  // A fresh result appears as the block returns to ready after working.
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready && $past(!s_tready))
    else $error("result appeared outside a request's completion");

endmodule

bind rgb_linear_color_fade_core rlcf_checker u_rlcf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear RGB colour fade core.
// ----------------------------------------------------------------------------
// A queue of requests is built at time zero: a short directed sequence that
// covers the corner cases, then random fade sequences mixed with lock
// sequences, noise and interrupted fades. A clocked driver sends them in
// bursts, and a clocked monitor stalls the result side on a changing pattern.
// Every accepted request runs through a local colour fade predictor, and every
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes that the core does not define; they must leave the state alone.
  localparam logic [rlcf_pkg::CmdW-1:0] CmdSpareFirst = 3'd5;
  localparam logic [rlcf_pkg::CmdW-1:0] CmdSpareLast  = 3'd7;

  localparam int unsigned NumRandomReqs = 600;
  localparam int unsigned SettleCycles  = 50;
  localparam int unsigned MaxReported   = 10;

  typedef logic [rlcf_pkg::NumChan-1:0][rlcf_pkg::ChanW-1:0] rgb_t;

  typedef struct packed {
    logic                       hold_for_drain;
    logic [rlcf_pkg::CmdW-1:0]  cmd;
    logic [rlcf_pkg::SkipW-1:0] delay;
    logic [rlcf_pkg::StepW-1:0] steps;
    rgb_t                       goal;
    rgb_t                       start;
  } fade_req_t;

  typedef struct packed {
    logic [rlcf_pkg::ChanW-1:0] red;
    logic [rlcf_pkg::ChanW-1:0] green;
    logic [rlcf_pkg::ChanW-1:0] blue;
    logic                       fading;
    logic                       held;
  } fade_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [rlcf_pkg::InDataW-1:0]  s_tdata  = '0;
  logic [rlcf_pkg::CmdW-1:0]     s_tuser  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [rlcf_pkg::OutDataW-1:0] m_tdata;

  rgb_linear_color_fade_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Requests waiting to be sent and the results the predictor expects back.
  fade_req_t request_q[$];
  fade_res_t expected_colour_q[$];

  int unsigned total_reqs    = 0;
  int unsigned reqs_accepted = 0;
  int unsigned mismatches    = 0;

  // Predictor state, mirroring the core's registers.
  rgb_t                       colour_now   = '0;
  rgb_t                       colour_goal  = '0;
  logic [rlcf_pkg::StepW-1:0] steps_left   = '0;
  logic [rlcf_pkg::SkipW-1:0] skips_left   = '0;
  logic                       start_locked = 1'b0;

  // One channel step: the remaining difference over the steps left, truncated
  // toward zero, with the sum held at the ends of the channel range.
  function automatic logic [rlcf_pkg::ChanW-1:0] fade_channel(
    logic [rlcf_pkg::ChanW-1:0] now,
    logic [rlcf_pkg::ChanW-1:0] goal,
    logic [rlcf_pkg::StepW-1:0] steps);
    int diff;
    int delta;
    int sum;
    diff  = int'(goal) - int'(now);
    delta = diff / int'(steps);
    sum   = int'(now) + delta;
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;
    return sum[rlcf_pkg::ChanW-1:0];
  endfunction

  function automatic string res_text(fade_res_t r);
    return $sformatf("r=%0d g=%0d b=%0d fading=%0b held=%0b",
                     r.red, r.green, r.blue, r.fading, r.held);
  endfunction

  task automatic predict_fade(input fade_req_t rq);
    fade_res_t res;
    if (rq.cmd == rlcf_pkg::CMD_START_KEEP || rq.cmd == rlcf_pkg::CMD_START_SKIP) begin
      if (!start_locked) begin
        colour_now  = rq.start;
        colour_goal = rq.goal;
        steps_left  = rq.steps;
        if (rq.cmd == rlcf_pkg::CMD_START_SKIP) skips_left = rq.delay;
      end
    end else if (rq.cmd == rlcf_pkg::CMD_TICK) begin
      if (skips_left != 0) begin
        skips_left = skips_left - 1'b1;
      end else if (steps_left != 0) begin
        for (int c = 0; c < rlcf_pkg::NumChan; c++) begin
          colour_now[c] = fade_channel(colour_now[c], colour_goal[c], steps_left);
        end
        steps_left = steps_left - 1'b1;
      end
    end else if (rq.cmd == rlcf_pkg::CMD_LOCK) begin
      start_locked = 1'b1;
    end else if (rq.cmd == rlcf_pkg::CMD_UNLOCK) begin
      start_locked = 1'b0;
    end
    res.red    = colour_now[0];
    res.green  = colour_now[1];
    res.blue   = colour_now[2];
    res.fading = (steps_left != 0);
    res.held   = start_locked;
    expected_colour_q.push_back(res);
  endtask

  // Colours are written as 24'hBBGGRR, red in the low byte.
  function automatic fade_req_t make_req(logic [rlcf_pkg::CmdW-1:0] cmd, rgb_t start,
                                         rgb_t goal, logic [rlcf_pkg::StepW-1:0] steps,
                                         logic [rlcf_pkg::SkipW-1:0] delay);
    fade_req_t rq;
    rq.hold_for_drain = 1'b0;
    rq.cmd   = cmd;
    rq.start = start;
    rq.goal  = goal;
    rq.steps = steps;
    rq.delay = delay;
    return rq;
  endfunction

  function automatic fade_req_t random_req(logic [rlcf_pkg::CmdW-1:0] cmd,
                                           logic [rlcf_pkg::StepW-1:0] steps,
                                           logic [rlcf_pkg::SkipW-1:0] delay);
    return make_req(cmd, rgb_t'($urandom), rgb_t'($urandom), steps, delay);
  endfunction

  function automatic fade_req_t tick_req();
    return random_req(rlcf_pkg::CMD_TICK, rlcf_pkg::StepW'($urandom),
                      rlcf_pkg::SkipW'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: the whole request queue is built before reset is released.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned counted;
    int unsigned ticks;
    int unsigned pick;
    logic [rlcf_pkg::StepW-1:0] steps;
    logic [rlcf_pkg::SkipW-1:0] delay;
    fade_req_t rq;

    // Directed part. A tick straight after reset must report black and idle.
    request_q.push_back(tick_req());
    request_q.push_back(random_req(rlcf_pkg::CMD_UNLOCK, '0, '0));
    // Opposite extremes on red and green, blue unchanged, with the longest fade.
    request_q.push_back(make_req(rlcf_pkg::CMD_START_KEEP, 24'h80_00_ff, 24'h80_ff_00,
                                 8'd255, '0));
    request_q.push_back(tick_req());
    request_q.push_back(tick_req());
    // Single-step fade behind two skipped frames, then a tick with nothing left.
    request_q.push_back(make_req(rlcf_pkg::CMD_START_SKIP, 24'h00_ff_00, 24'hff_00_ff,
                                 8'd1, 15'd2));
    repeat (4) request_q.push_back(tick_req());
    // A fade that keeps running while starts are locked out; locked starts,
    // including one carrying the largest skip count, are dropped entirely.
    request_q.push_back(make_req(rlcf_pkg::CMD_START_KEEP, 24'h5a_0a_c8, 24'h5a_fa_07,
                                 8'd3, '0));
    request_q.push_back(random_req(rlcf_pkg::CMD_LOCK, '0, '0));
    request_q.push_back(random_req(rlcf_pkg::CMD_START_KEEP, 8'd9, '0));
    request_q.push_back(random_req(rlcf_pkg::CMD_START_SKIP, 8'd9, 15'h7fff));
    request_q.push_back(tick_req());
    request_q.push_back(random_req(rlcf_pkg::CMD_UNLOCK, '0, '0));
    // Undefined command codes report the state unchanged.
    for (int c = CmdSpareFirst; c <= CmdSpareLast; c++) begin
      request_q.push_back(random_req(rlcf_pkg::CmdW'(c), rlcf_pkg::StepW'($urandom),
                                     rlcf_pkg::SkipW'($urandom)));
    end
    // A zero-step start jumps to the start colour and then never moves.
    request_q.push_back(make_req(rlcf_pkg::CMD_START_SKIP, 24'h38_22_0c, 24'hff_ff_ff,
                                 8'd0, 15'd0));
    request_q.push_back(tick_req());
    // Largest skip count, one frame of it consumed, then cleared by a new start.
    request_q.push_back(make_req(rlcf_pkg::CMD_START_SKIP, 24'h10_20_30, 24'h40_50_60,
                                 8'd4, 15'h7fff));
    request_q.push_back(tick_req());
    request_q.push_back(make_req(rlcf_pkg::CMD_START_SKIP, 24'h10_20_30, 24'h40_50_60,
                                 8'd4, 15'd0));

    // Random part, shaped as sequences.
    counted = 0;
    while (counted < NumRandomReqs) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // A fade: a start followed by the ticks to finish it, but never more than 24.
        pick  = $urandom_range(0, 99);
        steps = (pick < 10) ? 8'd0 :
                (pick < 15) ? rlcf_pkg::StepW'($urandom) :
                              rlcf_pkg::StepW'($urandom_range(1, 12));
        delay = ($urandom_range(0, 19) == 0) ? rlcf_pkg::SkipW'($urandom) :
                                               rlcf_pkg::SkipW'($urandom_range(0, 3));
        rq = random_req($urandom_range(0, 1) ? rlcf_pkg::CMD_START_SKIP :
                                               rlcf_pkg::CMD_START_KEEP, steps, delay);
        ticks = steps + delay + $urandom_range(0, 2);
        if (ticks > 24) ticks = 24;
      end else if (pick < 75) begin
        // Lock, some dropped starts, ticks while locked, unlock.
        rq = random_req(rlcf_pkg::CMD_LOCK, '0, '0);
        ticks = 0;
      end else if (pick < 85) begin
        rq = random_req(rlcf_pkg::CmdW'($urandom_range(0, 7)), rlcf_pkg::StepW'($urandom),
                        rlcf_pkg::SkipW'($urandom));
        ticks = 0;
      end else begin
        // A fade interrupted after a few ticks by whatever follows.
        rq = random_req(rlcf_pkg::CMD_START_SKIP, rlcf_pkg::StepW'($urandom_range(4, 20)),
                        '0);
        ticks = $urandom_range(1, 3);
      end
      rq.hold_for_drain = ($urandom_range(0, 49) == 0);
      request_q.push_back(rq);
      counted++;
      if (rq.cmd == rlcf_pkg::CMD_LOCK && pick >= 65 && pick < 75) begin
        repeat ($urandom_range(1, 2)) begin
          request_q.push_back(random_req($urandom_range(0, 1) ? rlcf_pkg::CMD_START_SKIP :
                                                                rlcf_pkg::CMD_START_KEEP,
                                         rlcf_pkg::StepW'($urandom),
                                         rlcf_pkg::SkipW'($urandom)));
        end
        repeat ($urandom_range(1, 3)) request_q.push_back(tick_req());
        request_q.push_back(random_req(rlcf_pkg::CMD_UNLOCK, '0, '0));
        counted += 2;
      end else if (pick >= 75 && pick < 85 && $urandom_range(0, 1)) begin
        request_q.push_back(random_req(rlcf_pkg::CMD_UNLOCK, '0, '0));
        counted++;
      end
      repeat (ticks) request_q.push_back(tick_req());
      counted += ticks;
    end

    // The first random request always waits for the core to drain completely.
    request_q[24].hold_for_drain = 1'b1;
    total_reqs = request_q.size();
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of requests separated by random gaps. A request marked to
  // wait is held back until every outstanding result has been received.
  // --------------------------------------------------------------------------
  fade_req_t   req_in_flight;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_fade(req_in_flight);
        reqs_accepted++;
      end
      // The slot is free when nothing is presented or the current request
      // has just been taken.
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].hold_for_drain && expected_colour_q.size() > 0)) begin
          req_in_flight = request_q.pop_front();
          s_tdata  <= {1'b0, req_in_flight.delay, req_in_flight.steps,
                       req_in_flight.goal, req_in_flight.start};
          s_tuser  <= req_in_flight.cmd;
          s_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: m_tready follows a 16-bit stall pattern that is redrawn each time it
  // runs out; a quarter of the patterns never stall.
  // --------------------------------------------------------------------------
  logic [15:0] stall_pattern = '1;
  logic [3:0]  stall_phase   = '0;

  always @(posedge clk) begin
    fade_res_t got;
    fade_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.red    = m_tdata[7:0];
        got.green  = m_tdata[15:8];
        got.blue   = m_tdata[23:16];
        got.fading = m_tdata[24];
        got.held   = m_tdata[25];
        if (expected_colour_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("%0t: result with nothing expected: %s", $realtime, res_text(got));
          end
        end else begin
          want = expected_colour_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= MaxReported) begin
              $display("%0t: result mismatch: expected %s, got %s",
                       $realtime, res_text(want), res_text(got));
            end
          end
        end
      end
      if (stall_phase == 4'hf) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      end
      stall_phase = stall_phase + 1'b1;
      m_tready <= stall_pattern[stall_phase];
    end
  end

  // --------------------------------------------------------------------------
  // End of run: all requests taken, all results back, then a short settle
  // period so that any stray extra result is still caught.
  // --------------------------------------------------------------------------
  initial begin
    @(negedge rst);
    while (total_reqs == 0 || reqs_accepted < total_reqs) @(posedge clk);
    while (expected_colour_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && expected_colour_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rlcf_pkg.sv
hdl/rlcf_div.sv
hdl/rgb_linear_color_fade_core.sv
hdl/rlcf_checker.sv
tb/tb_top.sv
